FILE: rtl/exp_taylor_series_core_defines.svh
// Assertion macros shared by the exp_taylor_series_core RTL.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef EXP_TAYLOR_SERIES_CORE_DEFINES_SVH
`define EXP_TAYLOR_SERIES_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ETR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ETR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/etr_pkg.sv
// Shared types and constants of the exponential Taylor series core.
// Depends on nothing; used by etr_ctrl, etr_dpath and the top level.
package etr_pkg;

  localparam int ARG_W        = 29;  // argument, signed Q4.24
  localparam int ARG_FRAC     = 24;
  localparam int CFG_W        = 11;  // term count register
  localparam int OUT_W        = 44;  // result, unsigned Q12.32
  localparam int MAG_W        = 62;  // term magnitude, capped at 2^61
  localparam int TERM_CAP_BIT = 61;
  localparam int SUM_W        = 64;  // signed running sum
  localparam int MUL_SPLIT    = 31;  // low half width of the magnitude
  localparam int PROD_W       = MAG_W + ARG_W;
  localparam int DIGIT_BITS   = 8;   // quotient bits per divider cycle
  localparam int DIGITS       = (PROD_W - ARG_FRAC + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int DIV_W        = DIGITS * DIGIT_BITS;
  localparam int DIGIT_CNT_W  = $clog2(DIGITS);

  localparam logic [CFG_W-1:0]        TERM_COUNT_RESET = 11'd1000;
  localparam logic [MAG_W-1:0]        TERM_CAP = 62'h2000_0000_0000_0000;
  localparam logic signed [SUM_W-1:0] SUM_CAP  = 64'sh4000_0000_0000_0000;
  localparam logic [SUM_W-1:0]        OUT_MAX  = 64'h0000_0FFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV_LOAD,
    ST_DIV,
    ST_TERM,
    ST_ACCUM,
    ST_DONE
  } etr_state_e;

  typedef struct packed {
    logic init;
    logic mul_lo;
    logic mul_hi;
    logic div_load;
    logic div_step;
    logic term_upd;
    logic accum;
    logic n_inc;
    logic out_load;
  } etr_cmd_t;

  typedef struct packed {
    logic first_ok;  // at least one term beyond the leading one
    logic more;      // another term follows the current one
    logic mag_zero;  // term has truncated to zero
  } etr_status_t;

endpackage

FILE: rtl/exp_taylor_series_core.sv
// Top level of the exponential Taylor series core.
// Depends on etr_pkg, etr_ctrl and etr_dpath.

// exp(x) by a truncated Taylor series in fixed point. The argument is signed
// Q4.24 and the result unsigned Q12.32 with a flag that is set when the sum
// was clamped at zero or at the top of the range, or a term or the running
// sum hit its internal cap. The term_count register (reset 1000, limited to
// MAX_TERMS) sets how many terms are summed, counting the leading one; it is
// written through cfg_we_i and cfg_wdata_i and must only change while the
// core is idle. One argument is in flight at a time. Each term after the
// first is formed in steps: the product of the 62-bit term magnitude with
// |x| in two halves, its alignment, the nine-digit radix-256 long division
// by the term index n, the term update and the add to the sum. The loop
// ends after term_count-1 terms beyond the leading one or as soon as a term
// truncates to zero, so k, the number of terms computed, sets how long an
// item takes from its transfer in to its result being valid and when the
// next argument can transfer; for arguments in -8..8 and 40 fraction bits
// k stays below about 80. The result sits in an output register, so a new
// argument is taken while the previous result still waits for its transfer.
module exp_taylor_series_core #(
  parameter int MAX_TERMS = 1024,
  parameter int FRAC_BITS = 40
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [etr_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [etr_pkg::ARG_W-1:0] argument_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [etr_pkg::OUT_W-1:0]        exp_value_o,
  output logic                             saturated_o
);
  import etr_pkg::*;

  logic [CFG_W-1:0] term_count_q;
  etr_cmd_t         cmd;
  etr_status_t      status;

  // Term count register; no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= TERM_COUNT_RESET;
    end else if (cfg_we_i) begin
      term_count_q <= cfg_wdata_i;
    end
  end

  etr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  etr_dpath #(
    .MAX_TERMS (MAX_TERMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .term_count_i (term_count_q),
    .argument_i   (argument_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .exp_value_o  (exp_value_o),
    .saturated_o  (saturated_o)
  );

endmodule

FILE: rtl/etr_ctrl.sv
// Sequencer of the exponential Taylor series core.
// Depends on etr_pkg and exp_taylor_series_core_defines.svh.
`include "exp_taylor_series_core_defines.svh"

module etr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  etr_pkg::etr_status_t status_i,
  output etr_pkg::etr_cmd_t   cmd_o
);
  import etr_pkg::*;

  localparam logic [DIGIT_CNT_W-1:0] DIGIT_LAST = DIGIT_CNT_W'(DIGITS - 1);

  etr_state_e             state_q, state_d;
  logic [DIGIT_CNT_W-1:0] digit_q, digit_d;
  logic                   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      digit_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      digit_q     <= digit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    digit_d = (state_q == ST_DIV) ? digit_q + 1'b1 : '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.first_ok ? ST_MUL_LO : ST_DONE;
        end
      end
      ST_MUL_LO:   state_d = ST_MUL_HI;
      ST_MUL_HI:   state_d = ST_DIV_LOAD;
      ST_DIV_LOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (digit_q == DIGIT_LAST) begin
          state_d = ST_TERM;
        end
      end
      ST_TERM:     state_d = ST_ACCUM;
      ST_ACCUM: begin
        state_d = (status_i.mag_zero || !status_i.more) ? ST_DONE : ST_MUL_LO;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.init = in_valid_i;
      end
      ST_MUL_LO:   cmd_o.mul_lo   = 1'b1;
      ST_MUL_HI:   cmd_o.mul_hi   = 1'b1;
      ST_DIV_LOAD: cmd_o.div_load = 1'b1;
      ST_DIV:      cmd_o.div_step = 1'b1;
      ST_TERM:     cmd_o.term_upd = 1'b1;
      ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        cmd_o.n_inc = !status_i.mag_zero && status_i.more;
      end
      ST_DONE:     cmd_o.out_load = !out_valid_q || out_ready_i;
      default:     cmd_o = '0;
    endcase
    out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);
  end

  assign out_valid_o = out_valid_q;

  `ETR_ASSERT_IMP(a_load_into_free_slot, cmd_o.out_load, !out_valid_q || out_ready_i, "result overwritten before transfer")
  `ETR_ASSERT_IMP(a_digit_in_range, state_q == ST_DIV, digit_q <= DIGIT_LAST, "divider digit counter out of range")
  `ETR_ASSERT_NXT(a_result_held, out_valid_q && !out_ready_i, out_valid_q, "pending result dropped")

endmodule

FILE: rtl/etr_dpath.sv
// Datapath of the exponential Taylor series core: split multiplier,
// radix-256 long divider, term and sum registers, output conversion.
// Depends on etr_pkg and exp_taylor_series_core_defines.svh.
`include "exp_taylor_series_core_defines.svh"

module etr_dpath #(
  parameter int MAX_TERMS = 1024,
  parameter int FRAC_BITS = 40
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [etr_pkg::CFG_W-1:0]        term_count_i,
  input  logic signed [etr_pkg::ARG_W-1:0] argument_i,
  input  etr_pkg::etr_cmd_t                cmd_i,
  output etr_pkg::etr_status_t             status_o,
  output logic [etr_pkg::OUT_W-1:0]        exp_value_o,
  output logic                             saturated_o
);
  import etr_pkg::*;

  localparam int N_W   = $clog2(MAX_TERMS);
  localparam int LIM_W = $clog2(MAX_TERMS + 1);
  localparam int CMP_W = (LIM_W > CFG_W) ? LIM_W : CFG_W;
  localparam int PLO_W = MUL_SPLIT + ARG_W;
  localparam int PHI_W = MAG_W - MUL_SPLIT + ARG_W;
  localparam int SH_R  = (FRAC_BITS >= 32) ? FRAC_BITS - 32 : 0;
  localparam int SH_L  = (FRAC_BITS < 32) ? 32 - FRAC_BITS : 0;
  localparam logic [MAG_W-1:0]        MAG_ONE = MAG_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0] SUM_ONE = SUM_W'(1) << FRAC_BITS;

  logic [ARG_W-1:0]        xm_q;
  logic                    xneg_q;
  logic [MAG_W-1:0]        mag_q;
  logic                    tneg_q;
  logic signed [SUM_W-1:0] term_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                    sat_q;
  logic [LIM_W-1:0]        n_q;
  logic [PLO_W-1:0]        plo_q;
  logic [PHI_W-1:0]        phi_q;
  logic [DIV_W-1:0]        div_q;
  logic [N_W-1:0]          rem_q;
  logic [OUT_W-1:0]        out_value_q;
  logic                    out_sat_q;

  logic [ARG_W-1:0]        arg_u;
  logic [ARG_W-1:0]        xm_init;
  logic [CMP_W-1:0]        limit;
  logic [N_W-1:0]          divisor;
  logic [PLO_W-1:0]        plo_d;
  logic [PHI_W-1:0]        phi_d;
  logic [PROD_W-1:0]       prod_sum;
  logic [DIV_W-1:0]        quo_v;
  logic [N_W-1:0]          rem_v;
  logic [N_W:0]            rem_ext;
  logic                    cap;
  logic [MAG_W-1:0]        mag_d;
  logic                    tneg_d;
  logic [SUM_W-1:0]        mag_ext;
  logic signed [SUM_W-1:0] term_d;
  logic signed [SUM_W-1:0] sum_raw;
  logic signed [SUM_W-1:0] sum_d;
  logic                    clamp;
  logic [SUM_W-1:0]        sum_u;
  logic [SUM_W-1:0]        shifted;
  logic                    over;
  logic                    neg;
  logic [OUT_W-1:0]        out_value_d;

  // Argument magnitude; the most negative pattern gives 2^28.
  assign arg_u   = unsigned'(argument_i);
  assign xm_init = arg_u[ARG_W-1] ? (~arg_u + ARG_W'(1)) : arg_u;

  assign limit = (CMP_W'(term_count_i) > CMP_W'(MAX_TERMS)) ?
                 CMP_W'(MAX_TERMS) : CMP_W'(term_count_i);
  assign divisor = n_q[N_W-1:0];

  assign status_o.first_ok = limit > CMP_W'(1);
  assign status_o.more     = (CMP_W'(n_q) + CMP_W'(1)) < limit;
  assign status_o.mag_zero = (mag_q == '0);

  // Magnitude times |x| in two halves.
  assign plo_d    = PLO_W'(mag_q[MUL_SPLIT-1:0]) * PLO_W'(xm_q);
  assign phi_d    = PHI_W'(mag_q[MAG_W-1:MUL_SPLIT]) * PHI_W'(xm_q);
  assign prod_sum = {phi_q, {MUL_SPLIT{1'b0}}} + PROD_W'(plo_q);

  // One quotient digit per cycle; the partial remainder stays below n.
  always_comb begin
    rem_v   = rem_q;
    quo_v   = div_q;
    rem_ext = '0;
    for (int i = 0; i < DIGIT_BITS; i++) begin
      rem_ext = {rem_v, quo_v[DIV_W-1]};
      quo_v   = {quo_v[DIV_W-2:0], 1'b0};
      if (rem_ext >= {1'b0, divisor}) begin
        rem_ext  = rem_ext - {1'b0, divisor};
        quo_v[0] = 1'b1;
      end
      rem_v = rem_ext[N_W-1:0];
    end
  end

  // Term update from the quotient.
  always_comb begin
    cap     = |div_q[DIV_W-1:TERM_CAP_BIT];
    mag_d   = cap ? TERM_CAP : div_q[MAG_W-1:0];
    tneg_d  = (tneg_q ^ xneg_q) && (mag_d != '0);
    mag_ext = SUM_W'(mag_d);
    term_d  = tneg_d ? -signed'(mag_ext) : signed'(mag_ext);
  end

  // Accumulate with clamping.
  always_comb begin
    sum_raw = sum_q + term_q;
    clamp   = 1'b0;
    sum_d   = sum_raw;
    if (sum_raw > SUM_CAP) begin
      sum_d = SUM_CAP;
      clamp = 1'b1;
    end else if (sum_raw < -SUM_CAP) begin
      sum_d = -SUM_CAP;
      clamp = 1'b1;
    end
  end

  // Conversion of the final sum to Q12.32.
  always_comb begin
    sum_u = unsigned'(sum_q);
    neg   = sum_q[SUM_W-1];
    if (FRAC_BITS >= 32) begin
      shifted = sum_u >> SH_R;
      over    = shifted > OUT_MAX;
    end else begin
      shifted = sum_u << SH_L;
      over    = sum_u > (OUT_MAX >> SH_L);
    end
    if (neg) begin
      out_value_d = '0;
    end else if (over) begin
      out_value_d = OUT_MAX[OUT_W-1:0];
    end else begin
      out_value_d = shifted[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      xm_q   <= xm_init;
      xneg_q <= arg_u[ARG_W-1];
      mag_q  <= MAG_ONE;
      tneg_q <= 1'b0;
      term_q <= SUM_ONE;
      sum_q  <= SUM_ONE;
      sat_q  <= 1'b0;
      n_q    <= LIM_W'(1);
    end
    if (cmd_i.mul_lo) begin
      plo_q <= plo_d;
    end
    if (cmd_i.mul_hi) begin
      phi_q <= phi_d;
    end
    if (cmd_i.div_load) begin
      div_q <= DIV_W'(prod_sum[PROD_W-1:ARG_FRAC]);
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      div_q <= quo_v;
      rem_q <= rem_v;
    end
    if (cmd_i.term_upd) begin
      mag_q  <= mag_d;
      tneg_q <= tneg_d;
      term_q <= term_d;
      sat_q  <= sat_q | cap;
    end
    if (cmd_i.accum) begin
      sum_q <= sum_d;
      sat_q <= sat_q | clamp;
    end
    if (cmd_i.n_inc) begin
      n_q <= n_q + LIM_W'(1);
    end
    if (cmd_i.out_load) begin
      out_value_q <= out_value_d;
      out_sat_q   <= sat_q | neg | over;
    end
  end

  assign exp_value_o = out_value_q;
  assign saturated_o = out_sat_q;

  `ETR_ASSERT_NXT(a_sum_bounded, cmd_i.accum, (sum_q <= SUM_CAP) && (sum_q >= -SUM_CAP), "sum outside clamp range")
  `ETR_ASSERT_NXT(a_mag_capped, cmd_i.term_upd, mag_q <= TERM_CAP, "term magnitude above cap")
  `ETR_ASSERT_NXT(a_rem_below_divisor, cmd_i.div_step, rem_q < divisor, "divider remainder not below n")

endmodule
